@@ rtl/rmq_pkg.sv @@
// Shared constants and width helpers for the rotation matrix to quaternion block.
// No dependencies; used by every file in rtl/.
package rmq_pkg;

    localparam int DATA_WIDTH_DEF = 16;
    localparam int FRAC_BITS_DEF  = 14;
    localparam int NUM_ENTRIES    = 9;
    localparam int NUM_COMPS      = 4;

    // entry order in the request word
    localparam int M00 = 0;
    localparam int M01 = 1;
    localparam int M02 = 2;
    localparam int M10 = 3;
    localparam int M11 = 4;
    localparam int M12 = 5;
    localparam int M20 = 6;
    localparam int M21 = 7;
    localparam int M22 = 8;

    // signed width that holds t and every raw component
    function automatic int t_width(input int dw, input int fb);
        return ((dw > fb) ? dw : fb + 1) + 3;
    endfunction

    function automatic int bytes_up(input int bits);
        return ((bits + 7) / 8) * 8;
    endfunction

endpackage

@@ rtl/rmq_branch.sv @@
// Branch selection: picks the dominant axis, forms t and the four raw components.
// Depends on rmq_pkg. One register stage.
module rmq_branch #(
    parameter int DATA_WIDTH = rmq_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = rmq_pkg::FRAC_BITS_DEF,
    parameter int TW         = rmq_pkg::t_width(rmq_pkg::DATA_WIDTH_DEF,
                                                rmq_pkg::FRAC_BITS_DEF)
) (
    input  logic                         i_clk,
    input  logic                         i_en,
    input  logic signed [DATA_WIDTH-1:0] i_m [rmq_pkg::NUM_ENTRIES],
    output logic signed [TW-1:0]         o_t,
    output logic signed [TW-1:0]         o_w,
    output logic signed [TW-1:0]         o_x,
    output logic signed [TW-1:0]         o_y,
    output logic signed [TW-1:0]         o_z,
    output logic                         o_bad
);

    logic signed [TW-1:0] e [rmq_pkg::NUM_ENTRIES];
    logic signed [TW-1:0] one;
    logic signed [TW-1:0] n_t, n_w, n_x, n_y, n_z;
    logic signed [TW-1:0] r_t, r_w, r_x, r_y, r_z;
    logic                 r_bad;

    always_comb begin
        for (int k = 0; k < rmq_pkg::NUM_ENTRIES; k++) begin
            e[k] = TW'(i_m[k]);
        end
    end

    assign one = TW'(1) <<< FRAC_BITS;

    always_comb begin
        if (e[rmq_pkg::M22] < 0) begin
            if (e[rmq_pkg::M00] > e[rmq_pkg::M11]) begin
                n_t = one + e[rmq_pkg::M00] - e[rmq_pkg::M11] - e[rmq_pkg::M22];
                n_x = n_t;
                n_y = e[rmq_pkg::M01] + e[rmq_pkg::M10];
                n_z = e[rmq_pkg::M02] + e[rmq_pkg::M20];
                n_w = e[rmq_pkg::M21] - e[rmq_pkg::M12];
            end else begin
                n_t = one - e[rmq_pkg::M00] + e[rmq_pkg::M11] - e[rmq_pkg::M22];
                n_x = e[rmq_pkg::M01] + e[rmq_pkg::M10];
                n_y = n_t;
                n_z = e[rmq_pkg::M12] + e[rmq_pkg::M21];
                n_w = e[rmq_pkg::M02] - e[rmq_pkg::M20];
            end
        end else begin
            if (e[rmq_pkg::M00] + e[rmq_pkg::M11] < 0) begin
                n_t = one - e[rmq_pkg::M00] - e[rmq_pkg::M11] + e[rmq_pkg::M22];
                n_x = e[rmq_pkg::M02] + e[rmq_pkg::M20];
                n_y = e[rmq_pkg::M12] + e[rmq_pkg::M21];
                n_z = n_t;
                n_w = e[rmq_pkg::M10] - e[rmq_pkg::M01];
            end else begin
                n_t = one + e[rmq_pkg::M00] + e[rmq_pkg::M11] + e[rmq_pkg::M22];
                n_x = e[rmq_pkg::M21] - e[rmq_pkg::M12];
                n_y = e[rmq_pkg::M02] - e[rmq_pkg::M20];
                n_z = e[rmq_pkg::M10] - e[rmq_pkg::M01];
                n_w = n_t;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_t   <= n_t;
            r_w   <= n_w;
            r_x   <= n_x;
            r_y   <= n_y;
            r_z   <= n_z;
            r_bad <= (n_t <= 0);
        end
    end

    assign o_t   = r_t;
    assign o_w   = r_w;
    assign o_x   = r_x;
    assign o_y   = r_y;
    assign o_z   = r_z;
    assign o_bad = r_bad;

endmodule

@@ rtl/rmq_scale.sv @@
// Scales one component by 0.5/sqrt(t): squaring stage, one result bit per stage
// using running k^2*t and k*t sums, then round/saturate register. Depends on rmq_pkg.
module rmq_scale #(
    parameter int DATA_WIDTH = rmq_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = rmq_pkg::FRAC_BITS_DEF,
    parameter int TW         = rmq_pkg::t_width(rmq_pkg::DATA_WIDTH_DEF,
                                                rmq_pkg::FRAC_BITS_DEF)
) (
    input  logic                         i_clk,
    input  logic                         i_en,
    input  logic signed [TW-1:0]         i_t,
    input  logic signed [TW-1:0]         i_c,
    output logic signed [DATA_WIDTH-1:0] o_q
);

    localparam int DW  = DATA_WIDTH;
    localparam int KW  = DW + 1;
    localparam int RW  = 2 * TW + FRAC_BITS;
    localparam int PW  = 2 * KW + TW;
    localparam int WW  = ((PW > RW) ? PW : RW) + 3;
    localparam int QW  = KW + TW + 1;

    logic [TW-1:0]          mag;
    logic [2*TW-1:0]        sq;

    logic [DW-1:0]          r_r   [DW+1];
    logic signed [WW-1:0]   r_p   [DW+1];
    logic signed [QW-1:0]   r_k   [DW+1];
    logic signed [TW-1:0]   r_t   [DW+1];
    logic [RW-1:0]          r_rr  [DW+1];
    logic                   r_neg [DW+1];
    logic signed [DW-1:0]   r_q;
    logic signed [DW-1:0]   n_q;
    logic [DW-1:0]          res;

    assign mag = i_c[TW-1] ? TW'(-i_c) : TW'(i_c);
    assign sq  = mag * mag;

    // r = 0, k = -1: k^2*t = t, k*t = -t
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_r[0]   <= '0;
            r_p[0]   <= WW'(i_t);
            r_k[0]   <= -QW'(i_t);
            r_t[0]   <= i_t;
            r_rr[0]  <= {sq, {FRAC_BITS{1'b0}}};
            r_neg[0] <= i_c[TW-1];
        end
    end

    for (genvar i = 0; i < DW; i++) begin : g_bit
        localparam int J = DW - 1 - i;
        logic signed [WW-1:0] cand_p;
        logic signed [QW-1:0] cand_k;
        logic                 ok;

        assign cand_p = r_p[i] + (WW'(r_k[i]) <<< (J + 2))
                               + (WW'(r_t[i]) <<< (2 * J + 2));
        assign cand_k = r_k[i] + (QW'(r_t[i]) <<< (J + 1));
        assign ok     = (cand_p <= signed'(WW'(r_rr[i])));

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_t[i+1]   <= r_t[i];
                r_rr[i+1]  <= r_rr[i];
                r_neg[i+1] <= r_neg[i];
                if (ok) begin
                    r_r[i+1] <= r_r[i] | (DW'(1) << J);
                    r_p[i+1] <= cand_p;
                    r_k[i+1] <= cand_k;
                end else begin
                    r_r[i+1] <= r_r[i];
                    r_p[i+1] <= r_p[i];
                    r_k[i+1] <= r_k[i];
                end
            end
        end
    end

    assign res = r_r[DW];

    always_comb begin
        if (r_neg[DW]) begin
            n_q = res[DW-1] ? {1'b1, {(DW-1){1'b0}}} : -signed'(res);
        end else begin
            n_q = res[DW-1] ? {1'b0, {(DW-1){1'b1}}} : signed'(res);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q <= n_q;
        end
    end

    assign o_q = r_q;

endmodule

@@ rtl/rotation_matrix_to_quaternion.sv @@
// Top level: rotation matrix (signed fixed point) to quaternion, fully pipelined.
// Depends on rmq_pkg, rmq_branch, rmq_scale.
//
//  channel | direction | handshake                | payload
//  s       | in        | i_s_tvalid / o_s_tready  | i_s_tdata: nine matrix entries
//  m       | out       | o_m_tvalid / i_m_tready  | o_m_tdata: w,x,y,z; o_m_tuser: bad_matrix
//
// Stages: one branch stage, one squaring stage, one stage per result bit of the root
// search, one round/saturate stage. One request per cycle while the output is not stalled.
// Reset clears the valid bits only. A stalled output freezes the whole pipeline;
// o_s_tready is high whenever the output register is empty or being taken.
module rotation_matrix_to_quaternion #(
    parameter int DATA_WIDTH = rmq_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = rmq_pkg::FRAC_BITS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_s_tvalid,
    output logic o_s_tready,
    // row0_col0, row0_col1, row0_col2, row1_col0 .. row2_col2, zero pad
    input  logic [rmq_pkg::bytes_up(rmq_pkg::NUM_ENTRIES*DATA_WIDTH)-1:0] i_s_tdata,
    output logic o_m_tvalid,
    input  logic i_m_tready,
    // quat_w, quat_x, quat_y, quat_z, zero pad
    output logic [rmq_pkg::bytes_up(rmq_pkg::NUM_COMPS*DATA_WIDTH)-1:0] o_m_tdata,
    // bad_matrix
    output logic [0:0] o_m_tuser
);

    localparam int TW  = rmq_pkg::t_width(DATA_WIDTH, FRAC_BITS);
    localparam int LAT = DATA_WIDTH + 3;
    localparam int OW  = rmq_pkg::bytes_up(rmq_pkg::NUM_COMPS * DATA_WIDTH);
    localparam int QB  = rmq_pkg::NUM_COMPS * DATA_WIDTH;

    logic                         en;
    logic signed [DATA_WIDTH-1:0] m [rmq_pkg::NUM_ENTRIES];
    logic signed [TW-1:0]         t_b, c_b [rmq_pkg::NUM_COMPS];
    logic                         bad_b;
    logic signed [DATA_WIDTH-1:0] q [rmq_pkg::NUM_COMPS];
    logic [LAT-1:0]               r_vld;
    logic [LAT-1:1]               r_bad;
    logic [QB-1:0]                quat;

    assign en         = !r_vld[LAT-1] || i_m_tready;
    assign o_s_tready = en;

    always_comb begin
        for (int k = 0; k < rmq_pkg::NUM_ENTRIES; k++) begin
            m[k] = signed'(i_s_tdata[k*DATA_WIDTH +: DATA_WIDTH]);
        end
    end

    rmq_branch #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS),
        .TW         (TW)
    ) u_branch (
        .i_clk (i_clk),
        .i_en  (en),
        .i_m   (m),
        .o_t   (t_b),
        .o_w   (c_b[0]),
        .o_x   (c_b[1]),
        .o_y   (c_b[2]),
        .o_z   (c_b[3]),
        .o_bad (bad_b)
    );

    for (genvar g = 0; g < rmq_pkg::NUM_COMPS; g++) begin : g_comp
        rmq_scale #(
            .DATA_WIDTH (DATA_WIDTH),
            .FRAC_BITS  (FRAC_BITS),
            .TW         (TW)
        ) u_scale (
            .i_clk (i_clk),
            .i_en  (en),
            .i_t   (t_b),
            .i_c   (c_b[g]),
            .o_q   (q[g])
        );
        assign quat[g*DATA_WIDTH +: DATA_WIDTH] = r_bad[LAT-1] ? '0 : q[g];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAT-2:0], i_s_tvalid};
        end
    end

    // bad_b lines up with r_vld[0]; r_bad[k] lines up with r_vld[k]
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_bad <= {r_bad[LAT-2:1], bad_b};
        end
    end

    assign o_m_tvalid = r_vld[LAT-1];
    assign o_m_tdata  = OW'(quat);
    assign o_m_tuser  = r_bad[LAT-1];

endmodule

@@ rtl/rmq_checker.sv @@
// Port-level checks for rotation_matrix_to_quaternion, bound to the top level.
// Depends on rmq_pkg.
module rmq_checker #(
    parameter int DATA_WIDTH = rmq_pkg::DATA_WIDTH_DEF
) (
    input logic i_clk,
    input logic i_rst_n,
    input logic o_s_tready,
    input logic o_m_tvalid,
    input logic i_m_tready,
    input logic [rmq_pkg::bytes_up(rmq_pkg::NUM_COMPS*DATA_WIDTH)-1:0] o_m_tdata,
    input logic [0:0] o_m_tuser
);

    localparam int QB = rmq_pkg::NUM_COMPS * DATA_WIDTH;

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid after reset");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata)
                                      && $stable(o_m_tuser))
        else $error("stalled result changed");

    a_ready_follows_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_tready == (!o_m_tvalid || i_m_tready))
        else $error("input ready does not track output side");

    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser[0] |-> o_m_tdata[QB-1:0] == '0)
        else $error("bad matrix with non-zero quaternion");

    a_stall_no_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |-> !o_s_tready)
        else $error("request taken while pipeline stalled");

endmodule

bind rotation_matrix_to_quaternion rmq_checker #(
    .DATA_WIDTH (DATA_WIDTH)
) u_rmq_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);
